@@ rtl/sspp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sspp_pkg;

  typedef enum logic [1:0] {
    MOTION_CW   = 2'd0,
    MOTION_CCW  = 2'd1,
    MOTION_STOP = 2'd2
  } motion_e;

  typedef enum logic {
    FUNC_MOVE = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  localparam int unsigned SPT_W      = 10;
  localparam int unsigned ANGLE_OUT_W = 9;
  localparam int unsigned STEPS_W    = 9;
  localparam int unsigned COIL_W     = 4;
  localparam int unsigned PHASE_W    = 3;

  localparam logic [SPT_W-1:0]   SPT_RESET  = 10'd513;
  localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd4;

  typedef struct packed {
    motion_e              sense;
    logic [STEPS_W-1:0]   steps;
  } move_t;

  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase,
                                                     input logic ccw);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'b0001;
      3'd1:    pat = 4'b0010;
      3'd2:    pat = 4'b0100;
      3'd3:    pat = 4'b1000;
      default: pat = 4'b0000;
    endcase
    if (ccw) begin
      pat = {pat[0], pat[1], pat[2], pat[3]};
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ rtl/stepper_shortest_path_positioner.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Stepper positioner with shortest-path moves and wave-drive coil sequencing.
// Request channel (in_valid_i/in_ready_o): func_i selects a move to
// target_angle_i or a time tick. Each request yields exactly one result on
// the result channel (out_valid_o/out_ready_i): coil pattern, direction,
// committed position, steps left and a refused flag for moves sent while
// the motor is still stepping.
// Config channel (cfg_valid_i/cfg_ready_o) writes steps per turn; write it
// only while no request is in flight. It is always ready.
// Path: a request is taken with target reduction into the input register,
// then move math goes into the result register. Throughput: one request per
// cycle, sustained while out_ready_i stays high.
// Stall: while out_ready_i is low the result holds and one more request is
// buffered in the input register; in_ready_o then drops.
// Reset: position 0, stopped, no steps pending, steps per turn 513.
module stepper_shortest_path_positioner #(
  parameter int FULL_TURN = 360
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic                            func_i,
  input  wire logic [8:0]                      target_angle_i,

  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [sspp_pkg::COIL_W-1:0]     coil_drive_o,
  output      logic [1:0]                      motion_o,
  output      logic [sspp_pkg::ANGLE_OUT_W-1:0] position_o,
  output      logic [sspp_pkg::STEPS_W-1:0]    steps_remaining_o,
  output      logic                            refused_o,

  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [sspp_pkg::SPT_W-1:0]      cfg_steps_per_turn_i
);

  localparam int ANGLE_W  = $clog2(FULL_TURN);
  localparam int PROD_W   = ANGLE_W + sspp_pkg::SPT_W;
  localparam int SHIFT    = PROD_W + ANGLE_W;
  localparam int RECIP_W  = PROD_W + 2;
  localparam int SCALE_W  = RECIP_W + sspp_pkg::SPT_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(FULL_TURN) - 64'd1) / longint'(FULL_TURN);
  localparam longint unsigned SCALE_RST = RECIP * longint'(sspp_pkg::SPT_RESET);
  localparam int TGT_SPAN  = 512;
  localparam int RED_STEPS = $clog2((TGT_SPAN + FULL_TURN - 1) / FULL_TURN);

  // target reduction modulo FULL_TURN
  logic [8:0]         tgt_red;
  logic [ANGLE_W-1:0] tgt_mod;

  always_comb begin
    tgt_red = target_angle_i;
    for (int i = RED_STEPS - 1; i >= 0; i--) begin
      if (32'(tgt_red) >= (FULL_TURN << i)) begin
        tgt_red = tgt_red - 9'(FULL_TURN << i);
      end
    end
    tgt_mod = ANGLE_W'(tgt_red);
  end

  // input register
  logic               a_valid_q;
  logic               a_func_q;
  logic [ANGLE_W-1:0] a_tgt_q;
  logic               advance;
  logic               out_valid_q;

  assign advance    = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_func_q <= func_i;
      a_tgt_q  <= tgt_mod;
    end
  end

  // steps per turn, kept pre-scaled by the reciprocal of FULL_TURN
  logic [SCALE_W-1:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(SCALE_RST);
    end else if (cfg_valid_i) begin
      scale_q <= SCALE_W'(cfg_steps_per_turn_i) * SCALE_W'(RECIP);
    end
  end

  // move math
  sspp_pkg::move_t mv;
  logic [ANGLE_W-1:0] shaft_q, shaft_d;

  sspp_move_calc #(
    .FULL_TURN (FULL_TURN),
    .ANGLE_W   (ANGLE_W),
    .SCALE_W   (SCALE_W),
    .SHIFT     (SHIFT)
  ) u_calc (
    .target_i (a_tgt_q),
    .shaft_i  (shaft_q),
    .scale_i  (scale_q),
    .move_o   (mv)
  );

  // motion state and result
  sspp_pkg::motion_e                sense_q, sense_d;
  logic [sspp_pkg::STEPS_W-1:0]     steps_q, steps_d;
  logic [sspp_pkg::PHASE_W-1:0]     phase_q, phase_d;
  logic [sspp_pkg::PHASE_W-1:0]     phase_cur;
  logic [sspp_pkg::COIL_W-1:0]      coil_q, coil_d;
  logic                             refused_q, refused_d;

  always_comb begin
    shaft_d   = shaft_q;
    sense_d   = sense_q;
    steps_d   = steps_q;
    phase_d   = phase_q;
    coil_d    = '0;
    refused_d = 1'b0;
    phase_cur = (phase_q <= sspp_pkg::PHASE_LAST) ? phase_q : '0;
    if (a_func_q == sspp_pkg::FUNC_MOVE) begin
      if (steps_q != '0) begin
        refused_d = 1'b1;
      end else begin
        shaft_d = a_tgt_q;
        sense_d = mv.sense;
        steps_d = mv.steps;
        phase_d = '0;
      end
    end else if (steps_q != '0) begin
      coil_d = sspp_pkg::coil_pattern(phase_cur, sense_q == sspp_pkg::MOTION_CCW);
      if (phase_cur == sspp_pkg::PHASE_LAST) begin
        phase_d = '0;
        steps_d = steps_q - sspp_pkg::STEPS_W'(1);
      end else begin
        phase_d = phase_cur + sspp_pkg::PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shaft_q     <= '0;
      sense_q     <= sspp_pkg::MOTION_STOP;
      steps_q     <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        shaft_q     <= shaft_d;
        sense_q     <= sense_d;
        steps_q     <= steps_d;
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      coil_q    <= coil_d;
      refused_q <= refused_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign coil_drive_o      = coil_q;
  assign motion_o          = sense_q;
  assign position_o        = sspp_pkg::ANGLE_OUT_W'(shaft_q);
  assign steps_remaining_o = steps_q;
  assign refused_o         = refused_q;

  a_steps_have_dir : assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q != '0 |-> sense_q != sspp_pkg::MOTION_STOP)
    else $error("steps pending while stopped");

  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= sspp_pkg::PHASE_LAST)
    else $error("phase index out of range");

  a_refused_moving : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && refused_q |-> steps_q != '0)
    else $error("move refused while idle");

  a_hold_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(steps_q) && $stable(shaft_q) && $stable(phase_q))
    else $error("motion state changed without a request");

endmodule

`default_nettype wire

@@ rtl/sspp_move_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shortest rotation toward the target, direction and step count.
// steps = floor(mag * spt / FULL_TURN) done as mag * (spt * recip) >> SHIFT.
module sspp_move_calc #(
  parameter int FULL_TURN = 360,
  parameter int ANGLE_W   = 9,
  parameter int SCALE_W   = 31,
  parameter int SHIFT     = 28
) (
  input  wire logic [ANGLE_W-1:0] target_i,
  input  wire logic [ANGLE_W-1:0] shaft_i,
  input  wire logic [SCALE_W-1:0] scale_i,
  output sspp_pkg::move_t         move_o
);

  localparam int HALF   = FULL_TURN / 2;
  localparam int DIFF_W = ANGLE_W + 2;
  localparam int PROD_W = ANGLE_W + SCALE_W;

  logic signed [DIFF_W-1:0] rs;
  logic signed [DIFF_W-1:0] rs_adj;
  logic [ANGLE_W-1:0]       r;
  logic [ANGLE_W-1:0]       mag;
  logic [PROD_W-1:0]        prod;

  always_comb begin
    rs = $signed({2'b00, target_i}) - $signed({2'b00, shaft_i})
         + $signed(DIFF_W'(HALF));
    if (rs[DIFF_W-1]) begin
      rs_adj = rs + $signed(DIFF_W'(FULL_TURN));
    end else if (rs >= $signed(DIFF_W'(FULL_TURN))) begin
      rs_adj = rs - $signed(DIFF_W'(FULL_TURN));
    end else begin
      rs_adj = rs;
    end
    r = ANGLE_W'(rs_adj);

    if (r >= ANGLE_W'(HALF)) begin
      mag = r - ANGLE_W'(HALF);
    end else begin
      mag = ANGLE_W'(HALF) - r;
    end

    prod = PROD_W'(mag) * PROD_W'(scale_i);

    if (r == ANGLE_W'(HALF)) begin
      move_o.sense = sspp_pkg::MOTION_STOP;
      move_o.steps = '0;
    end else begin
      move_o.sense = (r > ANGLE_W'(HALF)) ? sspp_pkg::MOTION_CW : sspp_pkg::MOTION_CCW;
      move_o.steps = prod[SHIFT +: sspp_pkg::STEPS_W];
    end
  end

endmodule

`default_nettype wire
